[hdl/exptok_pkg.sv]
// Shared types, codes and character tables for the expression tokenizer.
`default_nettype none

package exptok_pkg;

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_COS    = 4'd1,
    KIND_SIN    = 4'd2,
    KIND_TAN    = 4'd3,
    KIND_ADD    = 4'd4,
    KIND_SUB    = 4'd5,
    KIND_MUL    = 4'd6,
    KIND_DIV    = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_POW    = 4'd10,
    KIND_LN     = 4'd11,
    KIND_CONST  = 4'd12,
    KIND_VAR    = 4'd13,
    KIND_ERROR  = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_CONST   = 3'd1,
    MODE_VAR     = 3'd2,
    MODE_PREFIX  = 3'd3,
    MODE_DISCARD = 3'd4
  } mode_t;

  // keyword prefix codes
  localparam logic [2:0] PFX_NONE = 3'd0;
  localparam logic [2:0] PFX_C    = 3'd1;
  localparam logic [2:0] PFX_CO   = 3'd2;
  localparam logic [2:0] PFX_S    = 3'd3;
  localparam logic [2:0] PFX_SI   = 3'd4;
  localparam logic [2:0] PFX_T    = 3'd5;
  localparam logic [2:0] PFX_TA   = 3'd6;
  localparam logic [2:0] PFX_L    = 3'd7;

  localparam logic [11:0] START_MAX  = 12'd4095;
  localparam logic [12:0] LENGTH_MAX = 13'd8191;

  typedef struct packed {
    logic [12:0] length;
    logic [11:0] start;
    kind_t       kind;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // single-character token kind, KIND_END when none
  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "+":     k = KIND_ADD;
      "-":     k = KIND_SUB;
      "*":     k = KIND_MUL;
      "/":     k = KIND_DIV;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "^":     k = KIND_POW;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // prefix code started by a character, PFX_NONE when none
  function automatic logic [2:0] first_prefix(input logic [7:0] c);
    logic [2:0] p;
    case (c)
      "c":     p = PFX_C;
      "s":     p = PFX_S;
      "t":     p = PFX_T;
      "l":     p = PFX_L;
      default: p = PFX_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] prefix_next_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      PFX_C:   c = "o";
      PFX_CO:  c = "s";
      PFX_S:   c = "i";
      PFX_SI:  c = "n";
      PFX_T:   c = "a";
      PFX_TA:  c = "n";
      PFX_L:   c = "n";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // keyword completed from a prefix, KIND_END when it only advances
  function automatic kind_t prefix_done_kind(input logic [2:0] p);
    kind_t k;
    case (p)
      PFX_CO:  k = KIND_COS;
      PFX_SI:  k = KIND_SIN;
      PFX_TA:  k = KIND_TAN;
      PFX_L:   k = KIND_LN;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hdl/expression_tokenizer.sv]
// Expression tokenizer: one character per transaction in, tokens out.
//
//  channel  direction  tdata                          tlast
//  s_*      in         character[7:0]                 last_char
//  m_*      out        kind[3:0] start[15:4]          last_of_run
//                      length[28:16], zero[31:29]
//
// Each accepted character is lexed into a result register of up to three tokens;
// these leave at one per cycle while m_tready is high. s_tready is high while the
// register is empty or its final token is taken, so with m_tready high a character
// causing one token or none keeps the input at one per cycle; more tokens stall it.
// rst returns the lexer to token start with position zero; no clearing pass.
`default_nettype none

module expression_tokenizer #(
  parameter int MAX_CHARS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // character
  input  wire logic        s_tlast,   // last_char
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // token_kind, token_start, token_length, zero pad
  output      logic        m_tlast    // last_of_run
);

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int EW = (PW > 13) ? PW : 13;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_CHARS);
  localparam logic [PW-1:0] ONE     = PW'(1);

  function automatic logic [11:0] sat_start(input logic [PW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(exptok_pkg::START_MAX)) ? exptok_pkg::START_MAX : e[11:0];
  endfunction

  function automatic logic [12:0] sat_length(input logic [PW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(exptok_pkg::LENGTH_MAX)) ? exptok_pkg::LENGTH_MAX : e[12:0];
  endfunction

  // lexer state
  exptok_pkg::mode_t mode, mode_next, mode_a;
  logic [2:0]        prefix, prefix_next, prefix_a;
  logic [PW-1:0]     start_pos, start_pos_next, start_a;
  logic [PW-1:0]     pos, pos_next, pos_a;

  // result register
  exptok_pkg::token_t slot [3];
  logic [1:0]         cnt;
  logic [1:0]         idx;
  logic               full;

  // decode
  logic              accept;
  logic              drain_last;
  logic              do_char;
  logic              in_discard;
  logic              overflow;
  logic              run_mode;
  logic              match;
  logic              run_ends;
  logic              starts_token;
  logic              c_digit;
  logic              c_alnum;
  logic              c_space;
  exptok_pkg::kind_t c_op;
  exptok_pkg::kind_t done_kind;
  logic [2:0]        c_prefix;

  // token candidates in emission order
  exptok_pkg::token_t cand [4];
  logic [3:0]         cand_vld;
  exptok_pkg::token_t slot_new [3];
  logic [2:0]         n_new;

  assign c_digit   = exptok_pkg::is_digit(s_tdata);
  assign c_alnum   = exptok_pkg::is_alnum(s_tdata);
  assign c_space   = (s_tdata == " ");
  assign c_op      = exptok_pkg::op_kind(s_tdata);
  assign c_prefix  = exptok_pkg::first_prefix(s_tdata);
  assign done_kind = exptok_pkg::prefix_done_kind(prefix);

  assign do_char    = !(s_tlast && (s_tdata == 8'd0));
  assign in_discard = (mode == exptok_pkg::MODE_DISCARD);
  assign overflow   = (pos >= MAX_POS);
  assign run_mode   = (mode == exptok_pkg::MODE_CONST) || (mode == exptok_pkg::MODE_VAR) ||
                      (mode == exptok_pkg::MODE_PREFIX);
  assign match      = (mode == exptok_pkg::MODE_PREFIX) && (prefix != exptok_pkg::PFX_NONE) &&
                      (s_tdata == exptok_pkg::prefix_next_char(prefix));

  always_comb begin
    run_ends = 1'b0;
    if (do_char && !in_discard) begin
      if (overflow) begin
        run_ends = run_mode;
      end else begin
        case (mode)
          exptok_pkg::MODE_PREFIX: run_ends = !match && !c_alnum;
          exptok_pkg::MODE_CONST:  run_ends = !c_digit;
          exptok_pkg::MODE_VAR:    run_ends = !c_alnum;
          default:                 run_ends = 1'b0;
        endcase
      end
    end
  end

  assign starts_token = do_char && !in_discard && !overflow &&
                        ((mode == exptok_pkg::MODE_IDLE) || run_ends);

  // next state
  always_comb begin
    mode_a   = mode;
    prefix_a = prefix;
    start_a  = start_pos;
    pos_a    = pos;
    if (do_char) begin
      if (in_discard) begin
        if (pos < MAX_POS) begin
          pos_a = pos + ONE;
        end
      end else if (overflow) begin
        mode_a   = exptok_pkg::MODE_DISCARD;
        prefix_a = exptok_pkg::PFX_NONE;
      end else if (starts_token) begin
        pos_a    = pos + ONE;
        mode_a   = exptok_pkg::MODE_IDLE;
        prefix_a = exptok_pkg::PFX_NONE;
        if (!c_space && (c_op == exptok_pkg::KIND_END)) begin
          start_a = pos;
          if (c_prefix != exptok_pkg::PFX_NONE) begin
            mode_a   = exptok_pkg::MODE_PREFIX;
            prefix_a = c_prefix;
          end else if (c_digit) begin
            mode_a = exptok_pkg::MODE_CONST;
          end else if (c_alnum) begin
            mode_a = exptok_pkg::MODE_VAR;
          end else begin
            mode_a = exptok_pkg::MODE_DISCARD;
          end
        end
      end else begin
        pos_a = pos + ONE;
        if (match) begin
          if (done_kind != exptok_pkg::KIND_END) begin
            mode_a   = exptok_pkg::MODE_IDLE;
            prefix_a = exptok_pkg::PFX_NONE;
          end else begin
            prefix_a = prefix + 3'd1;
          end
        end else if (mode == exptok_pkg::MODE_PREFIX) begin
          mode_a   = exptok_pkg::MODE_VAR;
          prefix_a = exptok_pkg::PFX_NONE;
        end
      end
    end
    if (s_tlast) begin
      mode_next      = exptok_pkg::MODE_IDLE;
      prefix_next    = exptok_pkg::PFX_NONE;
      start_pos_next = '0;
      pos_next       = '0;
    end else begin
      mode_next      = mode_a;
      prefix_next    = prefix_a;
      start_pos_next = start_a;
      pos_next       = pos_a;
    end
  end

  // tokens caused by this character
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand[i] = '{length: 13'd0, start: 12'd0, kind: exptok_pkg::KIND_END};
    end
    cand_vld = 4'b0000;

    // pending run ended by this character
    cand_vld[0]      = run_ends;
    cand[0].kind     = (mode == exptok_pkg::MODE_CONST) ? exptok_pkg::KIND_CONST
                                                        : exptok_pkg::KIND_VAR;
    cand[0].start    = sat_start(start_pos);
    cand[0].length   = sat_length(pos - start_pos);

    // operator, keyword or error
    cand[1].length = 13'd1;
    cand[1].start  = sat_start(pos);
    if (do_char && !in_discard && overflow) begin
      cand_vld[1]   = 1'b1;
      cand[1].kind  = exptok_pkg::KIND_ERROR;
      cand[1].start = sat_start(MAX_POS);
    end else if (starts_token && (c_op != exptok_pkg::KIND_END)) begin
      cand_vld[1]  = 1'b1;
      cand[1].kind = c_op;
    end else if (starts_token && !c_space && !c_alnum) begin
      cand_vld[1]  = 1'b1;
      cand[1].kind = exptok_pkg::KIND_ERROR;
    end else if (do_char && !in_discard && !overflow && match &&
                 (done_kind != exptok_pkg::KIND_END)) begin
      cand_vld[1]    = 1'b1;
      cand[1].kind   = done_kind;
      cand[1].start  = sat_start(start_pos);
      cand[1].length = sat_length(pos + ONE - start_pos);
    end

    // run still open at the end of the expression
    cand_vld[2]    = s_tlast && ((mode_a == exptok_pkg::MODE_CONST) ||
                                 (mode_a == exptok_pkg::MODE_VAR) ||
                                 (mode_a == exptok_pkg::MODE_PREFIX));
    cand[2].kind   = (mode_a == exptok_pkg::MODE_CONST) ? exptok_pkg::KIND_CONST
                                                         : exptok_pkg::KIND_VAR;
    cand[2].start  = sat_start(start_a);
    cand[2].length = sat_length(pos_a - start_a);

    // end marker
    cand_vld[3]    = s_tlast;
    cand[3].kind   = exptok_pkg::KIND_END;
    cand[3].start  = sat_start(pos_a);
    cand[3].length = 13'd0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot_new[i] = cand[3];
    end
    n_new = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i]) begin
        if (n_new < 3'd3) begin
          slot_new[n_new[1:0]] = cand[i];
        end
        n_new = n_new + 3'd1;
      end
    end
  end

  assign drain_last = full && m_tready && (idx == cnt - 2'd1);
  assign s_tready   = !full || drain_last;
  assign accept     = s_tvalid && s_tready;

  assign m_tvalid = full;
  assign m_tdata  = {3'b000, slot[idx]};
  assign m_tlast  = (idx == cnt - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= exptok_pkg::MODE_IDLE;
      prefix    <= exptok_pkg::PFX_NONE;
      start_pos <= '0;
      pos       <= '0;
      full      <= 1'b0;
      idx       <= 2'd0;
      cnt       <= 2'd0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        prefix    <= prefix_next;
        start_pos <= start_pos_next;
        pos       <= pos_next;
      end
      if (accept && (n_new != 3'd0)) begin
        full <= 1'b1;
        idx  <= 2'd0;
        cnt  <= n_new[1:0];
      end else if (drain_last) begin
        full <= 1'b0;
        idx  <= 2'd0;
      end else if (full && m_tready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_new != 3'd0)) begin
      for (int i = 0; i < 3; i++) begin
        slot[i] <= slot_new[i];
      end
    end
  end

endmodule

`default_nettype wire
